// ===== design/mtep_pkg.sv =====
// shared types and codes for the midi track event parser
// used by the parser core, the result queue and the top level
package mtep_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// register index is taken from paddr[2]
	localparam logic REG_TRACK_LENGTH = 1'b0;

	localparam logic [3:0] EV_NOTEOFF   = 4'd0;
	localparam logic [3:0] EV_NOTEON    = 4'd1;
	localparam logic [3:0] EV_CONTROL   = 4'd2;
	localparam logic [3:0] EV_PROGRAM   = 4'd3;
	localparam logic [3:0] EV_CHANPRESS = 4'd4;
	localparam logic [3:0] EV_BEND      = 4'd5;
	localparam logic [3:0] EV_SYSEXBYTE = 4'd6;
	localparam logic [3:0] EV_SYSEXEND  = 4'd7;
	localparam logic [3:0] EV_TEMPO     = 4'd8;
	localparam logic [3:0] EV_DELTA     = 4'd9;
	localparam logic [3:0] EV_TRACKEND  = 4'd10;

	typedef struct packed {
		logic [3:0]  event_type;
		logic [3:0]  channel;
		logic [7:0]  first_param;
		logic [7:0]  second_param;
		logic [31:0] wide_value;
		logic        sysex_ok;
	} res_t;

	// results of one byte, handed from the core to the result queue
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== design/mtep_if.sv =====
// valid/ready channel interfaces for track bytes in and parsed events out
// no dependencies
interface midi_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface midi_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_type;
	logic [3:0]  channel;
	logic [7:0]  first_param;
	logic [7:0]  second_param;
	logic [31:0] wide_value;
	logic        sysex_ok;

	modport source (output valid, output event_type, output channel, output first_param,
		output second_param, output wide_value, output sysex_ok, input ready);
	modport sink (input valid, input event_type, input channel, input first_param,
		input second_param, input wide_value, input sysex_ok, output ready);
endinterface

// ===== design/mtep_core.sv =====
// parser core: input byte register, track state and one-pass event decode
// depends on mtep_pkg
module mtep_core import mtep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_kind,
	input  logic [7:0]  in_byte,
	input  logic [31:0] track_length,
	input  logic        room,
	output push_t       push
);

	localparam logic [3:0] PH_DELTA    = 4'd0;
	localparam logic [3:0] PH_STATUS   = 4'd1;
	localparam logic [3:0] PH_PARAM1   = 4'd2;
	localparam logic [3:0] PH_PARAM2   = 4'd3;
	localparam logic [3:0] PH_SYSLEN   = 4'd4;
	localparam logic [3:0] PH_SYSDATA  = 4'd5;
	localparam logic [3:0] PH_ESCLEN   = 4'd6;
	localparam logic [3:0] PH_SKIP     = 4'd7;
	localparam logic [3:0] PH_METATYPE = 4'd8;
	localparam logic [3:0] PH_METALEN  = 4'd9;
	localparam logic [3:0] PH_METADATA = 4'd10;

	localparam logic [7:0] ST_SYSEX  = 8'hF0;
	localparam logic [7:0] ST_SONGPOS = 8'hF2;
	localparam logic [7:0] ST_SONGSEL = 8'hF3;
	localparam logic [7:0] ST_ESCAPE = 8'hF7;
	localparam logic [7:0] ST_META   = 8'hFF;
	localparam logic [7:0] META_END  = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;

	localparam logic [3:0] CL_NOTEOFF  = 4'h8;
	localparam logic [3:0] CL_NOTEON   = 4'h9;
	localparam logic [3:0] CL_CONTROL  = 4'hB;
	localparam logic [3:0] CL_PROGRAM  = 4'hC;
	localparam logic [3:0] CL_CHANPRESS = 4'hD;
	localparam logic [3:0] CL_BEND     = 4'hE;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  byte_s1;
	logic        go;

	logic [3:0]  phase_q, phase_d;
	logic [31:0] consumed_q, consumed_d;
	logic [7:0]  rstat_q, rstat_d;
	logic [7:0]  cstat_q, cstat_d;
	logic [7:0]  held_q, held_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] left_q, left_d;
	logic [7:0]  meta_q, meta_d;
	logic [23:0] tempo_q, tempo_d;
	logic [31:0] total_q, total_d;
	logic        ended_q, ended_d;

	logic [31:0] consumed1, left0, left1, acc_base, acc_new, left_dec, left_sat, idx;
	logic [23:0] tempo_n;
	logic [7:0]  cs_use, held_use, p2;
	logic        main_v, do_end, do_enter, run_delta, take_p1, chan_ev;
	res_t        main_r, end_r;

	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= in_kind;
			byte_s1 <= in_byte;
		end
	end

	assign consumed1 = consumed_q + 32'd1;
	assign left0     = (consumed_q >= track_length) ? 32'd0 : track_length - consumed_q;
	assign left1     = (consumed1 >= track_length) ? 32'd0 : track_length - consumed1;
	assign acc_base  = (phase_q == PH_DELTA || phase_q == PH_SYSLEN || phase_q == PH_ESCLEN
		|| phase_q == PH_METALEN) ? acc_q : 32'd0;
	assign acc_new   = {acc_base[24:0], byte_s1[6:0]};
	assign left_dec  = left_q - 32'd1;
	assign left_sat  = (left_q != 32'd0) ? left_dec : 32'd0;
	assign idx       = total_q - left_q;
	assign tempo_n   = (idx < 32'd3) ? {tempo_q[15:0], byte_s1} : tempo_q;

	always_comb begin
		end_r            = '0;
		end_r.event_type = EV_TRACKEND;
	end

	always_comb begin
		phase_d    = phase_q;
		consumed_d = consumed_q;
		rstat_d    = rstat_q;
		cstat_d    = cstat_q;
		held_d     = held_q;
		acc_d      = acc_q;
		left_d     = left_q;
		meta_d     = meta_q;
		tempo_d    = tempo_q;
		total_d    = total_q;
		ended_d    = ended_q;
		main_v     = 1'b0;
		main_r     = '0;
		do_end     = 1'b0;
		do_enter   = 1'b0;
		run_delta  = 1'b0;
		take_p1    = 1'b0;
		chan_ev    = 1'b0;
		p2         = 8'd0;
		cs_use     = cstat_q;
		held_use   = held_q;
		push       = '0;

		if (go) begin
			if (kind_s1) begin
				phase_d    = PH_DELTA;
				consumed_d = '0;
				rstat_d    = '0;
				cstat_d    = '0;
				held_d     = '0;
				acc_d      = '0;
				left_d     = '0;
				meta_d     = '0;
				tempo_d    = '0;
				total_d    = '0;
				ended_d    = 1'b0;
			end else if (ended_q) begin
				ended_d = 1'b1;
			end else if (left0 == 32'd0) begin
				do_end = 1'b1;
			end else begin
				case (phase_q)
					PH_DELTA: begin
						run_delta = 1'b1;
					end
					PH_STATUS: begin
						if (!byte_s1[7]) begin
							cstat_d = rstat_q;
							if (rstat_q >= 8'h80 && rstat_q < ST_SYSEX) begin
								take_p1 = 1'b1;
								cs_use  = rstat_q;
							end else begin
								run_delta = 1'b1;
							end
						end else begin
							consumed_d = consumed1;
							cstat_d    = byte_s1;
							if (byte_s1 < ST_SYSEX) begin
								rstat_d = byte_s1;
								phase_d = PH_PARAM1;
							end else begin
								acc_d = '0;
								case (byte_s1)
									ST_SYSEX:   phase_d = PH_SYSLEN;
									ST_ESCAPE:  phase_d = PH_ESCLEN;
									ST_SONGPOS: begin
										left_d  = 32'd2;
										phase_d = PH_SKIP;
									end
									ST_SONGSEL: begin
										left_d  = 32'd1;
										phase_d = PH_SKIP;
									end
									ST_META:    phase_d = PH_METATYPE;
									default:    do_enter = 1'b1;
								endcase
							end
						end
					end
					PH_PARAM1: begin
						take_p1 = 1'b1;
					end
					PH_PARAM2: begin
						consumed_d = consumed1;
						chan_ev    = 1'b1;
						p2         = byte_s1;
					end
					PH_SYSLEN, PH_ESCLEN, PH_METALEN: begin
						consumed_d = consumed1;
						acc_d      = acc_new;
						if (byte_s1[7]) begin
							if (left1 == 32'd0) begin
								do_end = 1'b1;
							end
						end else if (left1 < acc_new) begin
							do_end = 1'b1;
						end else begin
							total_d = acc_new;
							left_d  = acc_new;
							case (phase_q)
								PH_SYSLEN: begin
									if (acc_new == 32'd0) begin
										main_v            = 1'b1;
										main_r.event_type = EV_SYSEXEND;
										do_enter          = 1'b1;
									end else begin
										phase_d = PH_SYSDATA;
									end
								end
								PH_ESCLEN: begin
									if (acc_new == 32'd0) begin
										do_enter = 1'b1;
									end else begin
										phase_d = PH_SKIP;
									end
								end
								default: begin
									tempo_d = '0;
									if (meta_q == META_END) begin
										do_end = 1'b1;
									end else if (acc_new == 32'd0) begin
										do_enter = 1'b1;
									end else begin
										phase_d = PH_METADATA;
									end
								end
							endcase
						end
					end
					PH_SYSDATA: begin
						consumed_d         = consumed1;
						left_d             = left_dec;
						main_v             = 1'b1;
						main_r.first_param = byte_s1;
						if (left_dec == 32'd0) begin
							main_r.event_type = EV_SYSEXEND;
							main_r.sysex_ok   = (total_q > 32'd1) && (byte_s1 == ST_ESCAPE);
							do_enter          = 1'b1;
						end else begin
							main_r.event_type = EV_SYSEXBYTE;
						end
					end
					PH_SKIP: begin
						consumed_d = consumed1;
						left_d     = left_sat;
						if (left_sat == 32'd0) begin
							do_enter = 1'b1;
						end
					end
					PH_METATYPE: begin
						consumed_d = consumed1;
						meta_d     = byte_s1;
						acc_d      = '0;
						phase_d    = PH_METALEN;
					end
					PH_METADATA: begin
						consumed_d = consumed1;
						tempo_d    = tempo_n;
						left_d     = left_sat;
						if (idx == 32'd2 && meta_q == META_TEMPO && tempo_n != 24'd0) begin
							main_v            = 1'b1;
							main_r.event_type = EV_TEMPO;
							main_r.wide_value = {8'd0, tempo_n};
						end
						if (left_sat == 32'd0) begin
							do_enter = 1'b1;
						end
					end
					default: begin
						run_delta = 1'b1;
					end
				endcase

				// variable-length delta time byte
				if (run_delta) begin
					consumed_d = consumed1;
					acc_d      = acc_new;
					if (!byte_s1[7]) begin
						main_v            = 1'b1;
						main_r.event_type = EV_DELTA;
						main_r.wide_value = acc_new;
						if (left1 < 32'd3) begin
							do_end = 1'b1;
						end else begin
							phase_d = PH_STATUS;
						end
					end else if (left1 == 32'd0) begin
						do_end = 1'b1;
					end else begin
						phase_d = PH_DELTA;
					end
				end

				if (take_p1) begin
					consumed_d = consumed1;
					held_d     = byte_s1;
					held_use   = byte_s1;
					if (cs_use[7:4] == CL_PROGRAM || cs_use[7:4] == CL_CHANPRESS) begin
						chan_ev = 1'b1;
					end else begin
						phase_d = PH_PARAM2;
					end
				end

				if (chan_ev) begin
					main_r.channel     = cs_use[3:0];
					main_r.first_param = held_use;
					main_v             = 1'b1;
					case (cs_use[7:4])
						CL_NOTEOFF:   main_r.event_type = EV_NOTEOFF;
						CL_NOTEON: begin
							main_r.event_type   = EV_NOTEON;
							main_r.second_param = p2;
						end
						CL_CONTROL: begin
							main_r.event_type   = EV_CONTROL;
							main_r.second_param = p2;
						end
						CL_PROGRAM:   main_r.event_type = EV_PROGRAM;
						CL_CHANPRESS: main_r.event_type = EV_CHANPRESS;
						CL_BEND: begin
							main_r.event_type  = EV_BEND;
							main_r.first_param = 8'd0;
							main_r.wide_value  = {18'd0, p2[6:0], held_use[6:0]};
						end
						default: begin
							main_v = 1'b0;
							main_r = '0;
						end
					endcase
					do_enter = 1'b1;
				end

				if (do_enter) begin
					acc_d = '0;
					if (left1 == 32'd0) begin
						do_end = 1'b1;
					end else begin
						phase_d = PH_DELTA;
					end
				end
			end

			if (do_end) begin
				ended_d = 1'b1;
			end
			if (main_v) begin
				push.r0    = main_r;
				push.r1    = end_r;
				push.count = do_end ? 2'd2 : 2'd1;
			end else if (do_end) begin
				push.r0    = end_r;
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DELTA;
			consumed_q <= '0;
			rstat_q    <= '0;
			cstat_q    <= '0;
			held_q     <= '0;
			acc_q      <= '0;
			left_q     <= '0;
			meta_q     <= '0;
			tempo_q    <= '0;
			total_q    <= '0;
			ended_q    <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			consumed_q <= consumed_d;
			rstat_q    <= rstat_d;
			cstat_q    <= cstat_d;
			held_q     <= held_d;
			acc_q      <= acc_d;
			left_q     <= left_d;
			meta_q     <= meta_d;
			tempo_q    <= tempo_d;
			total_q    <= total_d;
			ended_q    <= ended_d;
		end
	end

endmodule

// ===== design/mtep_out_fifo.sv =====
// result queue: takes up to two words per cycle, hands out one per cycle while out_ready is high
// depends on mtep_pkg
module mtep_out_fifo import mtep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_word
);

	res_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_q, rd_q;
	logic [QUEUE_AW:0]    cnt_q;
	logic                 pop;

	assign room      = cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_word  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + QUEUE_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QUEUE_AW'(push.count);
			rd_q  <= rd_q + QUEUE_AW'(pop);
			cnt_q <= cnt_q + (QUEUE_AW + 1)'(push.count) - (QUEUE_AW + 1)'(pop);
		end
	end

endmodule

// ===== design/midi_track_event_parser.sv =====
// Track chunk parser for standard MIDI files. One byte word is taken per clock cycle
// whenever the result queue has room for two words; the byte is registered, decoded in
// a single pass against the parser state and its zero, one or two event words (an
// event, then possibly track end) enter a four-word queue, from which one event word
// leaves per cycle while the sink is ready. A byte is held in the byte register, and
// its event words in the queue, before they reach the output. Sustained rate is one
// byte per cycle while bytes give at most one event each and the sink is ready.
// track_length is at APB address 0 and must be written while the parser is idle; an
// input word with kind set restarts the track and keeps track_length.
// depends on mtep_pkg, mtep_if, mtep_core, mtep_out_fifo
module midi_track_event_parser import mtep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	midi_in_if.sink     in_ch,
	midi_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] track_length_q;
	logic        room;
	push_t       push;
	res_t        head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TRACK_LENGTH) ? track_length_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_length_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_TRACK_LENGTH) begin
			track_length_q <= pwdata;
		end
	end

	mtep_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_kind      (in_ch.kind),
		.in_byte      (in_ch.data_byte),
		.track_length (track_length_q),
		.room         (room),
		.push         (push)
	);

	mtep_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_word  (head)
	);

	assign out_ch.event_type   = head.event_type;
	assign out_ch.channel      = head.channel;
	assign out_ch.first_param  = head.first_param;
	assign out_ch.second_param = head.second_param;
	assign out_ch.wide_value   = head.wide_value;
	assign out_ch.sysex_ok     = head.sysex_ok;

`ifndef SYNTHESIS
	a_push_limit: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two words from one byte");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("words pushed without queue room");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.r1.event_type == EV_TRACKEND
			&& push.r0.event_type != EV_TRACKEND)
		else $error("second word of a byte is not a lone track end");
`endif

endmodule

// ===== tb/mtep_tb_pkg.sv =====
`timescale 1ns / 1ps
// status, meta and varlen codes shared by the parser checker and the test top
// no dependencies
package mtep_tb_pkg;

	// high nibble of channel status bytes
	localparam logic [3:0] CLS_NOTEOFF   = 4'h8;
	localparam logic [3:0] CLS_NOTEON    = 4'h9;
	localparam logic [3:0] CLS_POLY      = 4'hA;
	localparam logic [3:0] CLS_CONTROL   = 4'hB;
	localparam logic [3:0] CLS_PROGRAM   = 4'hC;
	localparam logic [3:0] CLS_CHANPRESS = 4'hD;
	localparam logic [3:0] CLS_BEND      = 4'hE;

	// system status bytes
	localparam logic [7:0] ST_SYSEX   = 8'hF0;
	localparam logic [7:0] ST_SONGPOS = 8'hF2;
	localparam logic [7:0] ST_SONGSEL = 8'hF3;
	localparam logic [7:0] ST_ESCAPE  = 8'hF7;
	localparam logic [7:0] ST_META    = 8'hFF;

	localparam logic [7:0] SYSEX_TERM = 8'hF7;
	localparam logic [7:0] META_EOT   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;

	localparam logic [7:0] VARLEN_MORE = 8'h80;

endpackage

// ===== tb/track_event_checker.sv =====
`timescale 1ns / 1ps
// watches the byte and event channels and the register port of the track parser,
// predicts the event words of every accepted byte word and compares them in order
// depends on mtep_pkg, mtep_tb_pkg, mtep_if
module track_event_checker import mtep_pkg::*, mtep_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	midi_in_if          in_ch,
	midi_out_if         out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending
);

	typedef enum logic [3:0] {
		S_DELTA, S_STATUS, S_PARAM1, S_PARAM2, S_SYSLEN, S_SYSDATA,
		S_ESCLEN, S_SKIP, S_METATYPE, S_METALEN, S_METADATA
	} stage_t;

	typedef enum {VL_MORE, VL_DONE, VL_OVERRUN} vl_t;

	stage_t      stage;
	logic [31:0] len_reg;
	logic [31:0] bytes_used;
	logic [7:0]  run_status;
	logic [7:0]  cur_status;
	logic [7:0]  param_hold;
	logic [31:0] vl_value;
	logic [31:0] body_left;
	logic [31:0] body_len;
	logic [7:0]  meta_code;
	logic [23:0] tempo_value;
	logic        track_done;

	res_t expected_events[$];
	int   mismatches = 0;
	int   waiting = 0;

	assign errors = mismatches;
	assign pending = waiting;

	function automatic logic [31:0] remaining();
		return (bytes_used >= len_reg) ? 32'd0 : len_reg - bytes_used;
	endfunction

	function automatic string describe(res_t e);
		return $sformatf("type %0d ch %0d p1 %02h p2 %02h wide %08h ok %0b", e.event_type,
			e.channel, e.first_param, e.second_param, e.wide_value, e.sysex_ok);
	endfunction

	task automatic clear_parser();
		stage = S_DELTA;
		bytes_used = '0;
		run_status = '0;
		cur_status = '0;
		param_hold = '0;
		vl_value = '0;
		body_left = '0;
		body_len = '0;
		meta_code = '0;
		tempo_value = '0;
		track_done = 1'b0;
	endtask

	task automatic add_event(input logic [3:0] kind_code, input logic [3:0] ch,
		input logic [7:0] p1, input logic [7:0] p2, input logic [31:0] wide, input logic ok);
		res_t e;
		e.event_type = kind_code;
		e.channel = ch;
		e.first_param = p1;
		e.second_param = p2;
		e.wide_value = wide;
		e.sysex_ok = ok;
		expected_events.push_back(e);
	endtask

	task automatic finish_track();
		add_event(EV_TRACKEND, 4'd0, 8'd0, 8'd0, 32'd0, 1'b0);
		track_done = 1'b1;
	endtask

	task automatic next_delta();
		vl_value = '0;
		if (remaining() == 0)
			finish_track();
		else
			stage = S_DELTA;
	endtask

	task automatic take_varlen(input logic [7:0] b, output vl_t r);
		bytes_used = bytes_used + 1;
		vl_value = {vl_value[24:0], b[6:0]};
		if (!b[7])
			r = VL_DONE;
		else if (remaining() == 0)
			r = VL_OVERRUN;
		else
			r = VL_MORE;
	endtask

	task automatic check_length(output bit fits);
		if (remaining() < vl_value) begin
			finish_track();
			fits = 1'b0;
		end else begin
			body_len = vl_value;
			body_left = vl_value;
			fits = 1'b1;
		end
	endtask

	task automatic channel_event(input logic [7:0] p2);
		logic [3:0] ch;
		ch = cur_status[3:0];
		case (cur_status[7:4])
			CLS_NOTEOFF: add_event(EV_NOTEOFF, ch, param_hold, 8'd0, 32'd0, 1'b0);
			CLS_NOTEON: add_event(EV_NOTEON, ch, param_hold, p2, 32'd0, 1'b0);
			CLS_CONTROL: add_event(EV_CONTROL, ch, param_hold, p2, 32'd0, 1'b0);
			CLS_PROGRAM: add_event(EV_PROGRAM, ch, param_hold, 8'd0, 32'd0, 1'b0);
			CLS_CHANPRESS: add_event(EV_CHANPRESS, ch, param_hold, 8'd0, 32'd0, 1'b0);
			CLS_BEND: add_event(EV_BEND, ch, 8'd0, 8'd0, {18'd0, p2[6:0], param_hold[6:0]}, 1'b0);
			default: ;
		endcase
		next_delta();
	endtask

	task automatic first_param(input logic [7:0] b);
		bytes_used = bytes_used + 1;
		param_hold = b;
		if (cur_status[7:4] == CLS_PROGRAM || cur_status[7:4] == CLS_CHANPRESS)
			channel_event(8'd0);
		else
			stage = S_PARAM2;
	endtask

	task automatic delta_step(input logic [7:0] b);
		vl_t r;
		take_varlen(b, r);
		if (r == VL_OVERRUN) begin
			finish_track();
		end else if (r == VL_DONE) begin
			add_event(EV_DELTA, 4'd0, 8'd0, 8'd0, vl_value, 1'b0);
			if (remaining() < 3)
				finish_track();
			else
				stage = S_STATUS;
		end
	endtask

	task automatic status_step(input logic [7:0] b);
		if (!b[7]) begin
			cur_status = run_status;
			if (cur_status[7] && cur_status < ST_SYSEX) begin
				first_param(b);
			end else begin
				vl_value = '0;
				stage = S_DELTA;
				delta_step(b);
			end
		end else begin
			bytes_used = bytes_used + 1;
			cur_status = b;
			if (b < ST_SYSEX) begin
				run_status = b;
				stage = S_PARAM1;
			end else begin
				vl_value = '0;
				case (b)
					ST_SYSEX: stage = S_SYSLEN;
					ST_ESCAPE: stage = S_ESCLEN;
					ST_SONGPOS: begin
						body_left = 32'd2;
						stage = S_SKIP;
					end
					ST_SONGSEL: begin
						body_left = 32'd1;
						stage = S_SKIP;
					end
					ST_META: stage = S_METATYPE;
					default: next_delta();
				endcase
			end
		end
	endtask

	task automatic parse_track_byte(input logic restart, input logic [7:0] b);
		vl_t         r;
		bit          fits;
		logic [31:0] idx;
		if (restart) begin
			clear_parser();
		end else if (!track_done) begin
			if (remaining() == 0) begin
				finish_track();
			end else begin
				case (stage)
					S_DELTA: delta_step(b);
					S_STATUS: status_step(b);
					S_PARAM1: first_param(b);
					S_PARAM2: begin
						bytes_used = bytes_used + 1;
						channel_event(b);
					end
					S_SYSLEN: begin
						take_varlen(b, r);
						if (r == VL_OVERRUN) begin
							finish_track();
						end else if (r == VL_DONE) begin
							check_length(fits);
							if (fits && body_left == 0) begin
								add_event(EV_SYSEXEND, 4'd0, 8'd0, 8'd0, 32'd0, 1'b0);
								next_delta();
							end else if (fits) begin
								stage = S_SYSDATA;
							end
						end
					end
					S_SYSDATA: begin
						bytes_used = bytes_used + 1;
						body_left = body_left - 1;
						if (body_left == 0) begin
							add_event(EV_SYSEXEND, 4'd0, b, 8'd0, 32'd0,
								body_len > 1 && b == SYSEX_TERM);
							next_delta();
						end else begin
							add_event(EV_SYSEXBYTE, 4'd0, b, 8'd0, 32'd0, 1'b0);
						end
					end
					S_ESCLEN: begin
						take_varlen(b, r);
						if (r == VL_OVERRUN) begin
							finish_track();
						end else if (r == VL_DONE) begin
							check_length(fits);
							if (fits && body_left == 0)
								next_delta();
							else if (fits)
								stage = S_SKIP;
						end
					end
					S_SKIP: begin
						bytes_used = bytes_used + 1;
						if (body_left != 0)
							body_left = body_left - 1;
						if (body_left == 0)
							next_delta();
					end
					S_METATYPE: begin
						bytes_used = bytes_used + 1;
						meta_code = b;
						vl_value = '0;
						stage = S_METALEN;
					end
					S_METALEN: begin
						take_varlen(b, r);
						if (r == VL_OVERRUN) begin
							finish_track();
						end else if (r == VL_DONE) begin
							check_length(fits);
							if (fits) begin
								tempo_value = '0;
								if (meta_code == META_EOT)
									finish_track();
								else if (body_left == 0)
									next_delta();
								else
									stage = S_METADATA;
							end
						end
					end
					S_METADATA: begin
						idx = body_len - body_left;
						bytes_used = bytes_used + 1;
						if (idx < 3)
							tempo_value = {tempo_value[15:0], b};
						if (body_left != 0)
							body_left = body_left - 1;
						if (idx == 2 && meta_code == META_TEMPO && tempo_value != 0)
							add_event(EV_TEMPO, 4'd0, 8'd0, 8'd0, {8'd0, tempo_value}, 1'b0);
						if (body_left == 0)
							next_delta();
					end
					default: begin
						stage = S_DELTA;
						vl_value = '0;
						delta_step(b);
					end
				endcase
			end
		end
	endtask

	task automatic check_event_word();
		res_t got;
		res_t want;
		got.event_type = out_ch.event_type;
		got.channel = out_ch.channel;
		got.first_param = out_ch.first_param;
		got.second_param = out_ch.second_param;
		got.wide_value = out_ch.wide_value;
		got.sysex_ok = out_ch.sysex_ok;
		if (expected_events.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected event word: %s", describe(got));
		end else begin
			want = expected_events.pop_front();
			if (got.event_type !== want.event_type || got.channel !== want.channel ||
				got.first_param !== want.first_param || got.second_param !== want.second_param ||
				got.wide_value !== want.wide_value || got.sysex_ok !== want.sysex_ok) begin
				mismatches++;
				if (mismatches <= 10)
					$display("event mismatch: expected %s, got %s", describe(want), describe(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			len_reg = '0;
			expected_events.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_TRACK_LENGTH)
				len_reg = pwdata;
			if (in_ch.valid && in_ch.ready)
				parse_track_byte(in_ch.kind, in_ch.data_byte);
			if (out_ch.valid && out_ch.ready)
				check_event_word();
		end
		waiting = expected_events.size();
	end

endmodule

// ===== tb/midi_track_event_parser_test.sv =====
`timescale 1ns / 1ps
// top of the track parser test: clock, reset, track length writes, byte stimulus and
// random stalls; the event checker beside the parser does the prediction
// depends on mtep_pkg, mtep_tb_pkg, mtep_if, track_event_checker, midi_track_event_parser
module midi_track_event_parser_test;
	import mtep_pkg::*;
	import mtep_tb_pkg::*;

	localparam int ITEM_TARGET = 400;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int words_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int hold_count = 0;
	logic hold_wanted = 1'b0;

	logic [7:0] track_bytes[$];

	midi_in_if in_bus();
	midi_out_if out_bus();

	midi_track_event_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	track_event_checker event_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_bus),
		.out_ch(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// event sink with random stalls and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else if (hold_wanted && hold_count < HOLD_CYCLES) begin
			out_bus.ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_word(input logic restart, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.kind <= restart;
		in_bus.data_byte <= b;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		words_sent++;
	endtask

	// wait until every predicted word is out and the pipeline has drained
	task automatic settle();
		in_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TRACK_LENGTH, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic play_bytes();
		foreach (track_bytes[i]) begin
			if ($urandom_range(49) == 0)
				send_word(1'b1, 8'($urandom()));
			send_word(1'b0, track_bytes[i]);
		end
	endtask

	task automatic add_delta(input int groups);
		for (int i = 0; i < groups; i++)
			track_bytes.push_back({i != groups - 1, 7'($urandom())});
	endtask

	task automatic add_length(input int len);
		if ($urandom_range(3) == 0)
			track_bytes.push_back(VARLEN_MORE);
		track_bytes.push_back(8'(len));
	endtask

	task automatic compose_track();
		int         n_events;
		int         sel;
		int         len;
		bit         zero_tempo;
		logic [7:0] st;
		logic [7:0] last_st;
		logic [7:0] sys;
		track_bytes.delete();
		last_st = 8'h00;
		n_events = $urandom_range(1, 8);
		for (int e = 0; e < n_events; e++) begin
			add_delta(($urandom_range(9) == 0) ? 5 : $urandom_range(1, 4));
			// data byte with no running status is read as another delta
			if (e == 0 && $urandom_range(4) == 0)
				track_bytes.push_back(8'($urandom_range(127)));
			sel = $urandom_range(99);
			if (sel < 50) begin
				if (last_st != 8'h00 && $urandom_range(2) == 0) begin
					st = last_st;
					track_bytes.push_back(8'($urandom_range(127)));
				end else begin
					st = {4'($urandom_range(CLS_NOTEOFF, CLS_BEND)), 4'($urandom())};
					last_st = st;
					track_bytes.push_back(st);
					track_bytes.push_back(8'($urandom()));
				end
				if (st[7:4] != CLS_PROGRAM && st[7:4] != CLS_CHANPRESS)
					track_bytes.push_back(8'($urandom()));
			end else if (sel < 60) begin
				len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
				track_bytes.push_back(ST_SYSEX);
				add_length(len);
				for (int i = 0; i < len; i++)
					track_bytes.push_back((i == len - 1 && $urandom_range(3) != 0) ?
						SYSEX_TERM : 8'($urandom()));
			end else if (sel < 66) begin
				len = $urandom_range(0, 4);
				track_bytes.push_back(ST_ESCAPE);
				add_length(len);
				repeat (len) track_bytes.push_back(8'($urandom()));
			end else if (sel < 72) begin
				if ($urandom_range(1) == 0) begin
					track_bytes.push_back(ST_SONGPOS);
					track_bytes.push_back(8'($urandom()));
					track_bytes.push_back(8'($urandom()));
				end else begin
					track_bytes.push_back(ST_SONGSEL);
					track_bytes.push_back(8'($urandom()));
				end
			end else if (sel < 76) begin
				do
					sys = 8'($urandom_range(8'hF1, 8'hFE));
				while (sys == ST_SONGPOS || sys == ST_SONGSEL || sys == ST_ESCAPE);
				track_bytes.push_back(sys);
			end else begin
				track_bytes.push_back(ST_META);
				if ($urandom_range(1) == 0) begin
					track_bytes.push_back(META_TEMPO);
					len = ($urandom_range(3) == 0) ? $urandom_range(0, 5) : 3;
					zero_tempo = ($urandom_range(7) == 0);
					add_length(len);
					repeat (len) track_bytes.push_back(zero_tempo ? 8'h00 : 8'($urandom()));
				end else begin
					do
						sys = 8'($urandom());
					while (sys == META_EOT);
					track_bytes.push_back(sys);
					// an overlong length runs past the end of most tracks
					len = ($urandom_range(19) == 0) ? 127 : $urandom_range(0, 4);
					add_length(len);
					if (len < 127)
						repeat (len) track_bytes.push_back(8'($urandom()));
				end
			end
		end
		if ($urandom_range(4) != 0) begin
			add_delta($urandom_range(1, 2));
			track_bytes.push_back(ST_META);
			track_bytes.push_back(META_EOT);
			track_bytes.push_back(8'h00);
		end
	endtask

	initial begin
		int          sel;
		int          track_count;
		logic [31:0] track_len;
		arst_n = 1'b0;
		in_bus.valid = 1'b0;
		in_bus.kind = 1'b0;
		in_bus.data_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty track
		apb_write(32'd0);
		send_word(1'b0, 8'hA5);
		settle();

		// longest track, longest delta, extreme fields, sysex, end of track meta
		apb_write(32'hFFFF_FFFF);
		hold_wanted <= 1'b1;
		send_word(1'b1, 8'h5A);
		track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, {CLS_NOTEON, 4'hF}, 8'h00, 8'hFF,
			8'h00, {CLS_BEND, 4'h0}, 8'h7F, 8'h7F, 8'h00, ST_SYSEX, 8'h02, 8'h41, SYSEX_TERM,
			8'h00, ST_META, META_EOT, 8'h00};
		play_bytes();

		track_count = 0;
		while (words_sent < ITEM_TARGET) begin
			compose_track();
			sel = $urandom_range(99);
			if (sel < 70)
				track_len = track_bytes.size();
			else if (sel < 82)
				track_len = track_bytes.size() - $urandom_range(1, 4);
			else if (sel < 92)
				track_len = track_bytes.size() + $urandom_range(1, 3);
			else if (sel < 96)
				track_len = 32'hFFFF_FFFF;
			else
				track_len = 32'd0;
			settle();
			case (track_count % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 67;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 67;
				end
				default: begin
					send_idle_pct = 11;
					stall_pct <= 11;
				end
			endcase
			apb_write(track_len);
			send_word(1'b1, 8'($urandom()));
			play_bytes();
			repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom()));
			track_count++;
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
